@@ rtl/life_cellular_automaton_grid_unit_macros.svh @@
`ifndef LIFE_CELLULAR_AUTOMATON_GRID_UNIT_MACROS_SVH
`define LIFE_CELLULAR_AUTOMATON_GRID_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lca_pkg.sv @@
package lca_pkg;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam int unsigned CFG_W = 7;
  localparam int unsigned OUT_W = 64;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam int unsigned NBR_W = 4;
  localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef logic [NBR_W-1:0] nbr_count_t;

endpackage

@@ rtl/lca_grid_mem.sv @@
module lca_grid_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lca_row_eval.sv @@
module lca_row_eval #(
  parameter int unsigned COLS = 64
) (
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] current,
  input  logic [COLS-1:0] below,
  output logic [COLS-1:0] next_row
);

  logic [COLS+1:0] pad_above;
  logic [COLS+1:0] pad_current;
  logic [COLS+1:0] pad_below;

  assign pad_above   = {1'b0, above, 1'b0};
  assign pad_current = {1'b0, current, 1'b0};
  assign pad_below   = {1'b0, below, 1'b0};

  // Each column counts its eight neighbors; columns beyond either edge read as dead.
  always_comb begin
    lca_pkg::nbr_count_t count;
    for (int c = 0; c < COLS; c++) begin
      count = lca_pkg::nbr_count_t'(pad_above[c]) + lca_pkg::nbr_count_t'(pad_above[c+1])
            + lca_pkg::nbr_count_t'(pad_above[c+2]) + lca_pkg::nbr_count_t'(pad_current[c])
            + lca_pkg::nbr_count_t'(pad_current[c+2]) + lca_pkg::nbr_count_t'(pad_below[c])
            + lca_pkg::nbr_count_t'(pad_below[c+1]) + lca_pkg::nbr_count_t'(pad_below[c+2]);
      next_row[c] = (count == lca_pkg::BIRTH_COUNT)
                 || (current[c] && (count == lca_pkg::SURVIVE_COUNT));
    end
  end

endmodule

@@ rtl/life_cellular_automaton_grid_unit.sv @@
// An accepted set passes through S_SET_WR and an accepted read through S_READ_DATA before S_RESULT,
// which issues the result once the output is not stalled; a rejected item goes straight to S_RESULT.
// Input stays stalled until the block is back in S_IDLE, so it takes no new item before the last is done.
// A generation sweeps the grid one row per cycle through a single row evaluator, then goes to S_RESULT.
// After reset the grid memory is cleared one row per cycle, with input stalled;
// both region registers reset to 64.
`include "life_cellular_automaton_grid_unit_macros.svh"

module life_cellular_automaton_grid_unit #(
  parameter int unsigned GRID_ROWS = 64,
  parameter int unsigned GRID_COLS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [lca_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    operation,
  input  logic [5:0]                    cell_row,
  input  logic [5:0]                    cell_col,
  input  logic                          cell_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lca_pkg::OUT_W-1:0]     row_bits,
  output logic                          status
);

  localparam int unsigned ROW_W    = $clog2(GRID_ROWS);
  localparam int unsigned SWP_W    = $clog2(GRID_ROWS + 2);
  localparam int unsigned CMP_W    = (SWP_W > 7) ? SWP_W : 7;
  localparam int unsigned ROWS_SAT = (GRID_ROWS > 127) ? 127 : GRID_ROWS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SET_WR,
    S_READ_DATA,
    S_SWEEP,
    S_RESULT
  } state_t;

  state_t                    state;
  logic [lca_pkg::CFG_W-1:0] rows_in_use;
  logic [lca_pkg::CFG_W-1:0] cols_in_use;
  logic [lca_pkg::CFG_W-1:0] eff_rows;
  logic [lca_pkg::CFG_W-1:0] eff_cols;
  logic [GRID_COLS-1:0]      col_mask;
  logic [SWP_W-1:0]          sweep_cnt;
  logic [SWP_W-1:0]          data_row;
  logic [SWP_W-1:0]          write_row;
  logic [ROW_W-1:0]          item_row;
  logic [5:0]                item_col;
  logic                      item_value;
  logic [lca_pkg::OUT_W-1:0] res_bits;
  logic                      res_status;
  logic [GRID_COLS-1:0]      win_above;
  logic [GRID_COLS-1:0]      win_current;
  logic [GRID_COLS-1:0]      sweep_in;
  logic [GRID_COLS-1:0]      eval_row;
  logic [GRID_COLS-1:0]      bit_sel;
  logic                      row_ok;
  logic                      col_ok;
  logic                      mem_we;
  logic [ROW_W-1:0]          mem_waddr;
  logic [GRID_COLS-1:0]      mem_wdata;
  logic [ROW_W-1:0]          mem_raddr;
  logic [GRID_COLS-1:0]      mem_rdata;

  assign eff_rows = (rows_in_use > lca_pkg::CFG_W'(ROWS_SAT)) ? lca_pkg::CFG_W'(ROWS_SAT)
                                                              : rows_in_use;
  assign eff_cols = (cols_in_use > lca_pkg::CFG_W'(GRID_COLS)) ? lca_pkg::CFG_W'(GRID_COLS)
                                                               : cols_in_use;

  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      col_mask[c] = lca_pkg::CFG_W'(c) < eff_cols;
    end
  end

  assign row_ok = {1'b0, cell_row} < eff_rows;
  assign col_ok = {1'b0, cell_col} < eff_cols;

  assign in_stall  = (state != S_IDLE);
  assign data_row  = sweep_cnt - SWP_W'(1);
  assign write_row = sweep_cnt - SWP_W'(2);

  // Rows outside the region, and the row past the bottom edge, enter the window as dead.
  assign sweep_in = ((sweep_cnt != '0) && (CMP_W'(data_row) < CMP_W'(eff_rows)))
                  ? (mem_rdata & col_mask) : '0;

  assign bit_sel = {{(GRID_COLS-1){1'b0}}, 1'b1} << item_col;

  lca_row_eval #(
    .COLS(GRID_COLS)
  ) u_row_eval (
    .above   (win_above),
    .current (win_current),
    .below   (sweep_in),
    .next_row(eval_row)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = item_row;
    mem_wdata = '0;
    mem_raddr = ROW_W'(cell_row);
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ROW_W'(sweep_cnt);
      end
      S_SET_WR: begin
        mem_we    = 1'b1;
        mem_wdata = item_value ? (mem_rdata | bit_sel) : (mem_rdata & ~bit_sel);
      end
      S_SWEEP: begin
        mem_we    = (sweep_cnt >= SWP_W'(2));
        mem_waddr = ROW_W'(write_row);
        mem_wdata = (CMP_W'(write_row) < CMP_W'(eff_rows)) ? (eval_row & col_mask) : '0;
        mem_raddr = ROW_W'(sweep_cnt);
      end
      S_IDLE, S_READ_DATA, S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  lca_grid_mem #(
    .DEPTH(GRID_ROWS),
    .WIDTH(GRID_COLS)
  ) u_grid_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= lca_pkg::CFG_RESET;
      cols_in_use <= lca_pkg::CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lca_pkg::CFG_ROWS: rows_in_use <= cfg_data;
        lca_pkg::CFG_COLS: cols_in_use <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      sweep_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (sweep_cnt == SWP_W'(GRID_ROWS - 1)) begin
            state <= S_IDLE;
          end
          sweep_cnt <= sweep_cnt + SWP_W'(1);
        end
        S_IDLE: begin
          if (in_valid) begin
            item_row   <= ROW_W'(cell_row);
            item_col   <= cell_col;
            item_value <= cell_value;
            res_bits   <= '0;
            unique case (lca_pkg::op_t'(operation))
              lca_pkg::OP_SET: begin
                if (row_ok && col_ok) begin
                  res_status <= lca_pkg::STATUS_OK;
                  state      <= S_SET_WR;
                end else begin
                  res_status <= lca_pkg::STATUS_ERR;
                  state      <= S_RESULT;
                end
              end
              lca_pkg::OP_STEP: begin
                res_status  <= lca_pkg::STATUS_OK;
                sweep_cnt   <= '0;
                win_above   <= '0;
                win_current <= '0;
                state       <= S_SWEEP;
              end
              lca_pkg::OP_READ: begin
                if (row_ok) begin
                  res_status <= lca_pkg::STATUS_OK;
                  state      <= S_READ_DATA;
                end else begin
                  res_status <= lca_pkg::STATUS_ERR;
                  state      <= S_RESULT;
                end
              end
              default: begin
                res_status <= lca_pkg::STATUS_ERR;
                state      <= S_RESULT;
              end
            endcase
          end
        end
        S_SET_WR: begin
          state <= S_RESULT;
        end
        S_READ_DATA: begin
          res_bits <= lca_pkg::OUT_W'(mem_rdata & col_mask);
          state    <= S_RESULT;
        end
        S_SWEEP: begin
          win_above   <= win_current;
          win_current <= sweep_in;
          sweep_cnt   <= sweep_cnt + SWP_W'(1);
          if (sweep_cnt == SWP_W'(GRID_ROWS + 1)) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            row_bits  <= res_bits;
            status    <= res_status;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LCA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled after a transaction")
  `LCA_ASSERT_NOW(a_write_owner, mem_we, (state == S_CLEAR) || (state == S_SET_WR) || (state == S_SWEEP), "grid written outside a write state")
  `LCA_ASSERT_NOW(a_sweep_in_region, (state == S_SWEEP) && mem_we, (mem_wdata & ~col_mask) == '0, "generation wrote a cell outside the region")
  `LCA_ASSERT_NEXT(a_result_issued, (state == S_RESULT) && !(out_valid && out_stall), out_valid && (state == S_IDLE), "pending result not issued")

endmodule

@@ dv/life_cellular_automaton_grid_unit_test.sv @@
`timescale 1ns / 100ps

module life_cellular_automaton_grid_unit_test;

  localparam int GRID_N = 64;

  typedef struct packed {
    lca_pkg::op_t op;
    logic [5:0]   row;
    logic [5:0]   col;
    logic         val;
  } cell_cmd_t;

  typedef struct packed {
    logic [63:0] bits;
    logic        stat;
  } row_result_t;

  typedef enum {PLAN_ITEM, PLAN_ROWS, PLAN_COLS} plan_kind_t;
  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    plan_kind_t   kind;
    lca_pkg::op_t op;
    logic [5:0]   row;
    logic [5:0]   col;
    logic         val;
    logic [6:0]   cfg;
    bit           typed;
    logic [63:0]  bits;
    logic         stat;
  } plan_entry_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic cfg_index;
  logic [lca_pkg::CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] operation;
  logic [5:0] cell_row;
  logic [5:0] cell_col;
  logic cell_value;
  logic out_valid;
  logic out_stall;
  logic [lca_pkg::OUT_W-1:0] row_bits;
  logic status;

  life_cellular_automaton_grid_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .cell_row(cell_row), .cell_col(cell_col),
    .cell_value(cell_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .row_bits(row_bits), .status(status)
  );

  logic [63:0] life_grid [GRID_N];
  logic [6:0] region_rows;
  logic [6:0] region_cols;
  row_result_t pending_row_results [$];

  int send_pct;
  int recv_pct;
  int hold_left;
  int hot_row;
  int hot_col;
  int mismatches;
  int results_checked;
  int cmds_sent;
  int generations_sent;
  int rejections_seen;

  plan_entry_t directed_plan [34] = '{
    '{PLAN_ITEM, lca_pkg::OP_READ, 6'd0,  6'd0,  1'b0, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_READ, 6'd63, 6'd0,  1'b0, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_NONE, 6'd63, 6'd63, 1'b1, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_ERR},
    '{PLAN_ITEM, lca_pkg::OP_SET,  6'd0,  6'd0,  1'b1, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_SET,  6'd63, 6'd63, 1'b1, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_READ, 6'd63, 6'd0,  1'b0, 7'd0,   1'b1,
      64'h8000_0000_0000_0000, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_SET,  6'd10, 6'd4,  1'b1, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_SET,  6'd10, 6'd5,  1'b1, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_SET,  6'd10, 6'd6,  1'b1, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_SET,  6'd63, 6'd63, 1'b0, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_STEP, 6'd0,  6'd0,  1'b0, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_READ, 6'd9,  6'd0,  1'b0, 7'd0,   1'b0, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_READ, 6'd10, 6'd0,  1'b0, 7'd0,   1'b0, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_READ, 6'd0,  6'd0,  1'b0, 7'd0,   1'b0, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ROWS, lca_pkg::OP_NONE, 6'd0,  6'd0,  1'b0, 7'd3,   1'b0, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_COLS, lca_pkg::OP_NONE, 6'd0,  6'd0,  1'b0, 7'd5,   1'b0, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_SET,  6'd3,  6'd0,  1'b1, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_ERR},
    '{PLAN_ITEM, lca_pkg::OP_SET,  6'd0,  6'd5,  1'b1, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_ERR},
    '{PLAN_ITEM, lca_pkg::OP_SET,  6'd2,  6'd4,  1'b1, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_READ, 6'd10, 6'd0,  1'b0, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_ERR},
    '{PLAN_ROWS, lca_pkg::OP_NONE, 6'd0,  6'd0,  1'b0, 7'd64,  1'b0, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_COLS, lca_pkg::OP_NONE, 6'd0,  6'd0,  1'b0, 7'd64,  1'b0, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_READ, 6'd10, 6'd0,  1'b0, 7'd0,   1'b0, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ROWS, lca_pkg::OP_NONE, 6'd0,  6'd0,  1'b0, 7'd0,   1'b0, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_SET,  6'd0,  6'd0,  1'b1, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_ERR},
    '{PLAN_ITEM, lca_pkg::OP_READ, 6'd0,  6'd0,  1'b0, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_ERR},
    '{PLAN_ITEM, lca_pkg::OP_STEP, 6'd0,  6'd0,  1'b0, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ROWS, lca_pkg::OP_NONE, 6'd0,  6'd0,  1'b0, 7'd127, 1'b0, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_COLS, lca_pkg::OP_NONE, 6'd0,  6'd0,  1'b0, 7'd127, 1'b0, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_READ, 6'd10, 6'd0,  1'b0, 7'd0,   1'b0, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ROWS, lca_pkg::OP_NONE, 6'd0,  6'd0,  1'b0, 7'd1,   1'b0, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_COLS, lca_pkg::OP_NONE, 6'd0,  6'd0,  1'b0, 7'd1,   1'b0, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_SET,  6'd0,  6'd0,  1'b1, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_OK},
    '{PLAN_ITEM, lca_pkg::OP_STEP, 6'd0,  6'd0,  1'b0, 7'd0,   1'b1, 64'd0, lca_pkg::STATUS_OK}
  };

  logic [6:0] phase_rows [10] = '{7'd64, 7'd127, 7'd8, 7'd64, 7'd64,
                                  7'd20, 7'd0, 7'd64, 7'd37, 7'd1};
  logic [6:0] phase_cols [10] = '{7'd64, 7'd127, 7'd8, 7'd3, 7'd64,
                                  7'd100, 7'd7, 7'd1, 7'd63, 7'd64};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int rows_eff();
    return (region_rows > GRID_N) ? GRID_N : int'(region_rows);
  endfunction

  function automatic int cols_eff();
    return (region_cols > GRID_N) ? GRID_N : int'(region_cols);
  endfunction

  function automatic logic [63:0] live_mask();
    if (cols_eff() >= 64) return '1;
    return (64'd1 << cols_eff()) - 64'd1;
  endfunction

  function automatic int cell_at(logic [63:0] w, int c);
    if (c < 0 || c > 63) return 0;
    return int'(w[c]);
  endfunction

  function automatic int trio_at(logic [63:0] w, int c);
    return cell_at(w, c - 1) + cell_at(w, c) + cell_at(w, c + 1);
  endfunction

  task automatic advance_generation();
    logic [63:0] above;
    logic [63:0] cur;
    logic [63:0] below;
    logic [63:0] nxt;
    logic [63:0] m;
    int nr;
    int nc;
    int n;
    nr = rows_eff();
    nc = cols_eff();
    m = live_mask();
    above = '0;
    for (int r = 0; r < GRID_N; r++) begin
      if (r >= nr) begin
        life_grid[r] = '0;
      end else begin
        cur = life_grid[r] & m;
        below = (r + 1 < nr) ? (life_grid[r + 1] & m) : '0;
        nxt = '0;
        for (int c = 0; c < nc; c++) begin
          n = trio_at(above, c) + trio_at(cur, c) - cell_at(cur, c) + trio_at(below, c);
          if (n == int'(lca_pkg::BIRTH_COUNT)
              || (cell_at(cur, c) == 1 && n == int'(lca_pkg::SURVIVE_COUNT)))
            nxt[c] = 1'b1;
        end
        life_grid[r] = nxt;
        above = cur;
      end
    end
  endtask

  task automatic apply_life_cmd(input cell_cmd_t cmd, output row_result_t res);
    res.bits = '0;
    res.stat = lca_pkg::STATUS_OK;
    case (cmd.op)
      lca_pkg::OP_SET: begin
        if (int'(cmd.row) < rows_eff() && int'(cmd.col) < cols_eff())
          life_grid[cmd.row][cmd.col] = cmd.val;
        else
          res.stat = lca_pkg::STATUS_ERR;
      end
      lca_pkg::OP_STEP: begin
        advance_generation();
      end
      lca_pkg::OP_READ: begin
        if (int'(cmd.row) < rows_eff())
          res.bits = life_grid[cmd.row] & live_mask();
        else
          res.stat = lca_pkg::STATUS_ERR;
      end
      default: begin
        res.stat = lca_pkg::STATUS_ERR;
      end
    endcase
  endtask

  function automatic cell_cmd_t random_life_cmd();
    cell_cmd_t cmd;
    int roll;
    int nr;
    int nc;
    int r;
    int c;
    nr = rows_eff();
    nc = cols_eff();
    roll = $urandom_range(0, 99);
    cmd.op = (roll < 45) ? lca_pkg::OP_SET
           : (roll < 58) ? lca_pkg::OP_STEP
           : (roll < 95) ? lca_pkg::OP_READ : lca_pkg::OP_NONE;
    cmd.row = 6'($urandom_range(0, 63));
    cmd.col = 6'($urandom_range(0, 63));
    cmd.val = ($urandom_range(0, 99) < 65);
    if (nr > 0 && nc > 0 && $urandom_range(0, 99) < 85) begin
      if ($urandom_range(0, 1) == 1) begin
        r = hot_row + $urandom_range(0, 7);
        c = hot_col + $urandom_range(0, 7);
        if (r >= nr) r = nr - 1;
        if (c >= nc) c = nc - 1;
      end else begin
        r = $urandom_range(0, nr - 1);
        c = $urandom_range(0, nc - 1);
      end
      cmd.row = 6'(r);
      cmd.col = 6'(c);
    end
    return cmd;
  endfunction

  task automatic set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_pct = 0;  recv_pct = 0;  end
      IDLE_SENDER:   begin send_pct = 87; recv_pct = 0;  end
      IDLE_RECEIVER: begin send_pct = 0;  recv_pct = 87; end
      default:       begin send_pct = 36; recv_pct = 36; end
    endcase
  endtask

  task automatic send_life_cmd(input cell_cmd_t cmd, input bit typed, input row_result_t fixed);
    row_result_t res;
    while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= cmd.op;
    cell_row <= cmd.row;
    cell_col <= cmd.col;
    cell_value <= cmd.val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_life_cmd(cmd, res);
    if (typed) res = fixed;
    pending_row_results.push_back(res);
    cmds_sent++;
    if (cmd.op == lca_pkg::OP_STEP) generations_sent++;
  endtask

  task automatic write_region(input logic idx, input logic [6:0] value);
    in_valid <= 1'b0;
    while (pending_row_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == lca_pkg::CFG_ROWS) region_rows = value;
    else region_cols = value;
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (recv_pct != 0 && $urandom_range(0, 99) < recv_pct);
      end
    end
  end

  always @(posedge clk) begin
    row_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_row_results.size() == 0) begin
        $error("unexpected transaction: row_bits %h, status %b", row_bits, status);
        mismatches++;
      end else begin
        want = pending_row_results.pop_front();
        results_checked++;
        if (status === lca_pkg::STATUS_ERR) rejections_seen++;
        if (row_bits !== want.bits) begin
          $error("row_bits: expected %h, got %h", want.bits, row_bits);
          mismatches++;
        end
        if (status !== want.stat) begin
          $error("status: expected %b, got %b", want.stat, status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    cell_cmd_t cmd;
    row_result_t fixed;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= lca_pkg::CFG_ROWS;
    cfg_data <= '0;
    in_valid <= 1'b0;
    operation <= lca_pkg::OP_SET;
    cell_row <= '0;
    cell_col <= '0;
    cell_value <= 1'b0;
    for (int r = 0; r < GRID_N; r++) life_grid[r] = '0;
    region_rows = lca_pkg::CFG_RESET;
    region_cols = lca_pkg::CFG_RESET;
    hold_left = 0;
    mismatches = 0;
    results_checked = 0;
    cmds_sent = 0;
    generations_sent = 0;
    rejections_seen = 0;
    set_idle_mode(IDLE_NONE);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    for (int i = 0; i < $size(directed_plan); i++) begin
      case (directed_plan[i].kind)
        PLAN_ROWS: write_region(lca_pkg::CFG_ROWS, directed_plan[i].cfg);
        PLAN_COLS: write_region(lca_pkg::CFG_COLS, directed_plan[i].cfg);
        default: begin
          cmd.op = directed_plan[i].op;
          cmd.row = directed_plan[i].row;
          cmd.col = directed_plan[i].col;
          cmd.val = directed_plan[i].val;
          fixed.bits = directed_plan[i].bits;
          fixed.stat = directed_plan[i].stat;
          send_life_cmd(cmd, directed_plan[i].typed, fixed);
        end
      endcase
    end

    for (int p = 0; p < 10; p++) begin
      if (p == 9) begin
        write_region(lca_pkg::CFG_ROWS, 7'($urandom_range(2, 64)));
        write_region(lca_pkg::CFG_COLS, 7'($urandom_range(2, 64)));
      end else begin
        write_region(lca_pkg::CFG_ROWS, phase_rows[p]);
        write_region(lca_pkg::CFG_COLS, phase_cols[p]);
      end
      hot_row = (rows_eff() > 8) ? $urandom_range(0, rows_eff() - 8) : 0;
      hot_col = (cols_eff() > 8) ? $urandom_range(0, cols_eff() - 8) : 0;
      set_idle_mode(idle_mode_t'(p % 4));
      // The receiver holds off long enough for the block to back up its input.
      if (p == 4) hold_left = 400;
      for (int k = 0; k < 140; k++) send_life_cmd(random_life_cmd(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_row_results.size() != 0) @(posedge clk);
    repeat (GRID_N + 8) @(posedge clk);
    $display("Ran %0d transactions, %0d of them generations, over the directed table",
             cmds_sent, generations_sent);
    $display("and ten random region phases; checked %0d results (%0d rejected).",
             results_checked, rejections_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lca_pkg.sv
rtl/lca_grid_mem.sv
rtl/lca_row_eval.sv
rtl/life_cellular_automaton_grid_unit.sv
dv/life_cellular_automaton_grid_unit_test.sv
